FILE: src/sle_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted list engine: opcodes, status codes, widths and the
// per-cell command bundle. Used by sle_cell and sorted_list_engine_unit.
package sle_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned DepthDef = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } sle_op_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DELETED  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_ENTRY    = 3'd5,
    ST_EMPTY    = 3'd6
  } sle_status_e;

  // broadcast to every cell in the row
  typedef struct packed {
    logic cmp_en;  // latch compare flags against the operand
    logic ins_en;  // open a gap at the insert point and drop the operand in
    logic del_en;  // close the gap left by the first equal entry
    logic rot_en;  // rotate the occupied part down by one (read-out)
  } sle_cmd_t;

endpackage

FILE: src/sle_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted row: holds an entry and its compare flags, and
// takes a neighbour's value on insert, delete or rotate. Depends on sle_pkg.
module sle_cell import sle_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sle_cmd_t                cmd_i,
  input  logic signed [DataW-1:0] operand_i,
  input  logic                    occ_i,
  input  logic                    first_i,      // this is slot 0
  input  logic                    left_less_i,
  input  logic signed [DataW-1:0] left_entry_i,
  input  logic                    right_occ_i,
  input  logic signed [DataW-1:0] right_entry_i,
  input  logic signed [DataW-1:0] head_entry_i,
  output logic signed [DataW-1:0] entry_o,
  output logic                    less_o,
  output logic                    eq_o
);

  logic signed [DataW-1:0] entry_q, entry_d;
  logic                    less_q, eq_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins_en && !less_q) begin
      entry_d = (first_i || left_less_i) ? operand_i : left_entry_i;
    end else if (cmd_i.del_en && occ_i && !less_q) begin
      entry_d = right_entry_i;
    end else if (cmd_i.rot_en) begin
      if (right_occ_i) begin
        entry_d = right_entry_i;
      end else if (occ_i) begin
        entry_d = head_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      less_q <= 1'b0;
      eq_q   <= 1'b0;
    end else if (cmd_i.cmp_en) begin
      less_q <= occ_i && (entry_q < operand_i);
      eq_q   <= occ_i && (entry_q == operand_i);
    end
  end

  assign entry_o = entry_q;
  assign less_o  = less_q;
  assign eq_o    = eq_q;

endmodule

FILE: src/sorted_list_engine_unit.sv
`timescale 1ns / 1ps
// Top level of the sorted list engine: control, entry count, output register
// and the row of sle_cell slots. Depends on sle_pkg and sle_cell.

// Keeps up to DEPTH signed 32-bit values in ascending order, one per cell of
// a shifting row. Insert, search and delete pass through a compare state, in
// which every cell compares its entry with the operand, and an apply state, in
// which the result is loaded into the output register and a successful insert
// or delete shifts the row up or down by one; the next transaction can be
// taken in the apply state. A read emits one entry per cycle from slot 0 while
// the output is not stalled, as the occupied cells rotate; after its last result
// is loaded the block goes back to idle, where the next transaction is taken.
// The list is back in place when the last entry leaves. An output stall holds
// the block at the point where it would load a result.
module sorted_list_engine_unit import sle_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              opcode_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              status_o,
  output logic signed [DataW-1:0] entry_value_o,
  output logic                    last_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_APPLY = 4'b0100,
    S_READ  = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  sle_op_e                 op_q;
  logic signed [DataW-1:0] val_q;
  logic [CntW-1:0]         count_q, count_d;
  logic [CntW-1:0]         rd_idx_q, rd_idx_d;

  logic                    out_valid_q, out_valid_d;
  sle_status_e             status_q, status_d;
  logic signed [DataW-1:0] out_val_q, out_val_d;
  logic                    last_q, last_d;

  sle_cmd_t                cmd;
  logic [DEPTH-1:0]        occ, less, eq;
  logic signed [DataW-1:0] entry [DEPTH];

  logic out_free, in_take, found, full, rd_last;

  assign out_free = !out_valid_q || !out_stall_i;
  assign found    = |eq;
  assign full     = (count_q == CntW'(DEPTH));
  assign rd_last  = (rd_idx_q == count_q - CntW'(1));

  assign in_stall_o = !((state_q == S_IDLE) || (state_q == S_APPLY && out_free));
  assign in_take    = in_valid_i && !in_stall_o;

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    left_less, right_occ;
    logic signed [DataW-1:0] left_entry, right_entry;

    assign occ[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_first
      assign left_less  = 1'b0;
      assign left_entry = val_q;
    end else begin : g_mid
      assign left_less  = less[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_occ   = 1'b0;
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_occ   = occ[i+1];
      assign right_entry = entry[i+1];
    end

    sle_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .operand_i    (val_q),
      .occ_i        (occ[i]),
      .first_i      (i == 0),
      .left_less_i  (left_less),
      .left_entry_i (left_entry),
      .right_occ_i  (right_occ),
      .right_entry_i(right_entry),
      .head_entry_i (entry[0]),
      .entry_o      (entry[i]),
      .less_o       (less[i]),
      .eq_o         (eq[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    cmd         = '0;
    out_valid_d = out_stall_i ? out_valid_q : 1'b0;
    status_d    = status_q;
    out_val_d   = out_val_q;
    last_d      = last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_take) state_d = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_en = 1'b1;
        rd_idx_d   = '0;
        state_d    = (op_q == OP_READ) ? S_READ : S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = val_q;
          last_d      = 1'b1;
          case (op_q)
            OP_INSERT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                cmd.ins_en = 1'b1;
                count_d    = count_q + CntW'(1);
                status_d   = ST_INSERTED;
              end
            end
            OP_SEARCH: status_d = found ? ST_FOUND : ST_NOTFOUND;
            default: begin
              if (found) begin
                cmd.del_en = 1'b1;
                count_d    = count_q - CntW'(1);
                status_d   = ST_DELETED;
              end else begin
                status_d = ST_NOTFOUND;
              end
            end
          endcase
          state_d = in_take ? S_CMP : S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (count_q == '0) begin
            status_d  = ST_EMPTY;
            out_val_d = '0;
            last_d    = 1'b1;
            state_d   = S_IDLE;
          end else begin
            cmd.rot_en = 1'b1;
            status_d   = ST_ENTRY;
            out_val_d  = entry[0];
            last_d     = rd_last;
            rd_idx_d   = rd_idx_q + CntW'(1);
            if (rd_last) state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q  <= sle_op_e'(opcode_i);
      val_q <= value_i;
    end
    status_q  <= status_d;
    out_val_q <= out_val_d;
    last_q    <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_value_o = out_val_q;
  assign last_o        = last_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY && out_free && status_d == ST_FULL) |-> full)
    else $error("full reported with room left");

  a_read_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && $past(state_q == S_READ)) |-> $stable(count_q))
    else $error("count moved during read-out");

  a_take_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> state_q == S_CMP)
    else $error("accepted transaction did not reach compare");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_list_engine_unit: directed table, then random
// insert/search/delete/read traffic under varying back-pressure, predicted in-line.
// Depends on sle_pkg and the RTL of the engine.
module tb;
  import sle_pkg::*;

  localparam int unsigned ListDepth    = DepthDef;
  localparam int unsigned RandPerPhase = 50;
  localparam int unsigned NumPhases    = 5;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned MaxReports   = 40;
  localparam int unsigned DirRows      = 26;

  typedef struct packed {
    sle_status_e             status;
    logic signed [DataW-1:0] value;
    logic                    last;
  } list_result_t;

  // fixed_exp rows carry their single result inline; the rest go via the predictor
  typedef struct packed {
    sle_op_e                 op;
    logic signed [DataW-1:0] val;
    logic                    fixed_exp;
    sle_status_e             st;
    logic signed [DataW-1:0] ev;
  } dir_row_t;

  localparam dir_row_t DirTab [DirRows] = '{
    '{OP_READ,   32'sd0,          1'b1, ST_EMPTY,    32'sd0},
    '{OP_DELETE, 32'sd5,          1'b1, ST_NOTFOUND, 32'sd5},
    '{OP_SEARCH, 32'sd0,          1'b1, ST_NOTFOUND, 32'sd0},
    '{OP_INSERT, 32'h7FFF_FFFF,   1'b1, ST_INSERTED, 32'h7FFF_FFFF},
    '{OP_INSERT, 32'h8000_0000,   1'b1, ST_INSERTED, 32'h8000_0000},
    '{OP_INSERT, 32'sd0,          1'b0, ST_INSERTED, 32'sd0},
    '{OP_INSERT, 32'hFFFF_FFFF,   1'b0, ST_INSERTED, 32'sd0},
    '{OP_INSERT, 32'sd0,          1'b0, ST_INSERTED, 32'sd0},
    '{OP_SEARCH, 32'h8000_0000,   1'b1, ST_FOUND,    32'h8000_0000},
    '{OP_READ,   32'hDEAD_BEEF,   1'b0, ST_INSERTED, 32'sd0},
    '{OP_DELETE, 32'sd0,          1'b1, ST_DELETED,  32'sd0},
    '{OP_INSERT, 32'hAAAA_AAAA,   1'b0, ST_INSERTED, 32'sd0},
    '{OP_INSERT, 32'h5555_5555,   1'b0, ST_INSERTED, 32'sd0},
    '{OP_INSERT, 32'sd1,          1'b0, ST_INSERTED, 32'sd0},
    '{OP_INSERT, -32'sd2,         1'b0, ST_INSERTED, 32'sd0},
    '{OP_INSERT, 32'sd2,          1'b0, ST_INSERTED, 32'sd0},
    '{OP_INSERT, 32'h7FFF_FFFF,   1'b0, ST_INSERTED, 32'sd0},
    '{OP_INSERT, 32'h8000_0000,   1'b0, ST_INSERTED, 32'sd0},
    '{OP_INSERT, 32'sd100,        1'b0, ST_INSERTED, 32'sd0},
    '{OP_INSERT, -32'sd100,       1'b0, ST_INSERTED, 32'sd0},
    '{OP_INSERT, 32'h1234_5678,   1'b0, ST_INSERTED, 32'sd0},
    '{OP_INSERT, 32'h8765_4321,   1'b0, ST_INSERTED, 32'sd0},
    '{OP_INSERT, 32'sd0,          1'b0, ST_INSERTED, 32'sd0},
    '{OP_INSERT, 32'sd3,          1'b1, ST_FULL,     32'sd3},
    '{OP_READ,   32'sd0,          1'b0, ST_INSERTED, 32'sd0},
    '{OP_DELETE, 32'h8000_0000,   1'b1, ST_DELETED,  32'h8000_0000}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              opcode_i;
  logic signed [DataW-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [2:0]              status_o;
  logic signed [DataW-1:0] entry_value_o;
  logic                    last_o;

  logic signed [DataW-1:0] list_img [$];      // predicted list contents
  list_result_t            step_results [$];  // results of the latest transaction
  list_result_t            pending_results [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req       = 1'b0;
  logic        hold_started   = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned err_cnt        = 0;
  int unsigned n_items        = 0;
  int unsigned n_results      = 0;
  int unsigned n_full         = 0;
  int unsigned n_empty        = 0;

  sorted_list_engine_unit #(
    .DEPTH(ListDepth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .entry_value_o(entry_value_o),
    .last_o       (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Applies one transaction to the predicted list and collects its results.
  function automatic void predict_list_op(input sle_op_e op, input logic signed [DataW-1:0] val);
    int unsigned pos;
    step_results.delete();
    pos = 0;
    case (op)
      OP_INSERT: begin
        if (list_img.size() >= ListDepth) begin
          step_results.push_back('{status: ST_FULL, value: val, last: 1'b1});
        end else begin
          // lands before any equal entries
          while (pos < list_img.size() && list_img[pos] < val) pos++;
          list_img.insert(pos, val);
          step_results.push_back('{status: ST_INSERTED, value: val, last: 1'b1});
        end
      end
      OP_SEARCH: begin
        while (pos < list_img.size() && list_img[pos] != val) pos++;
        step_results.push_back('{status: (pos < list_img.size()) ? ST_FOUND : ST_NOTFOUND,
                                 value: val, last: 1'b1});
      end
      OP_DELETE: begin
        while (pos < list_img.size() && list_img[pos] != val) pos++;
        if (pos < list_img.size()) begin
          list_img.delete(pos);
          step_results.push_back('{status: ST_DELETED, value: val, last: 1'b1});
        end else begin
          step_results.push_back('{status: ST_NOTFOUND, value: val, last: 1'b1});
        end
      end
      default: begin
        if (list_img.size() == 0) begin
          step_results.push_back('{status: ST_EMPTY, value: '0, last: 1'b1});
        end else begin
          foreach (list_img[i]) begin
            step_results.push_back('{status: ST_ENTRY, value: list_img[i],
                                     last: (i == list_img.size() - 1)});
          end
        end
      end
    endcase
  endfunction

  function automatic sle_op_e pick_op(input bit filling);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return OP_READ;
    if (r < 25) return OP_SEARCH;
    if (r < (filling ? 80 : 40)) return OP_INSERT;
    return OP_DELETE;
  endfunction

  // Mostly small values and entries already held, so duplicates and hits are common.
  function automatic logic signed [DataW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return int'($urandom_range(15)) - 8;
    if (r < 45) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        default: return '0;
      endcase
    end
    if (r < 60 || list_img.size() == 0) return $urandom;
    return list_img[$urandom_range(list_img.size() - 1)];
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer(input sle_op_e op, input logic signed [DataW-1:0] val,
                       input logic fixed_exp, input sle_status_e st,
                       input logic signed [DataW-1:0] ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    predict_list_op(op, val);
    foreach (step_results[i]) begin
      if (step_results[i].status == ST_FULL) n_full++;
      if (step_results[i].status == ST_EMPTY) n_empty++;
    end
    if (fixed_exp) begin
      pending_results.push_back('{status: st, value: ev, last: 1'b1});
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
    n_items++;
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req && !hold_started) begin
      hold_started <= 1'b1;
      hold_left    <= HoldCycles;
      out_stall_i  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results <= n_results + 1;
      if (pending_results.size() == 0) begin
        if (err_cnt < MaxReports) begin
          $error("unexpected result: status %0d, entry_value %0d, last %0b",
                 status_o, entry_value_o, last_o);
        end
        err_cnt <= err_cnt + 1;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || entry_value_o !== want.value || last_o !== want.last) begin
          if (err_cnt < MaxReports) begin
            if (status_o !== want.status)
              $error("status: expected %0d, got %0d", want.status, status_o);
            if (entry_value_o !== want.value)
              $error("entry_value: expected %0d, got %0d", $signed(want.value), entry_value_o);
            if (last_o !== want.last)
              $error("last: expected %0b, got %0b", want.last, last_o);
          end
          err_cnt <= err_cnt + 1;
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycle_cnt >= CycleLimit);
    $display("Timeout after %0d cycles, %0d results outstanding",
             cycle_cnt, pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    sle_op_e                 op;
    logic signed [DataW-1:0] val;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    opcode_i   = OP_INSERT;
    value_i    = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DirTab[r]) begin
      offer(DirTab[r].op, DirTab[r].val, DirTab[r].fixed_exp, DirTab[r].st, DirTab[r].ev);
    end

    // phases: free-running, sparse sender, slow receiver, light both, long hold-off
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
        3:       begin send_idle_pct = 6;  recv_stall_pct = 6;  end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      if (ph == NumPhases - 1) hold_req = 1'b1;
      for (int unsigned k = 0; k < RandPerPhase; k++) begin
        // alternate bursts that fill and drain the list
        op  = pick_op(((k / 20) % 2) == 0);
        val = pick_value();
        offer(op, val, 1'b0, ST_INSERTED, '0);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);

    $display("Ran %0d transactions (%0d from the directed table), checked %0d results.",
             n_items, DirRows, n_results);
    $display("Full-list inserts: %0d, empty reads: %0d, over %0d cycles.",
             n_full, n_empty, cycle_cnt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/sle_pkg.sv
src/sle_cell.sv
src/sorted_list_engine_unit.sv
tb/tb.sv
